// File: rtl/trajectory_collision_check_top_assert.svh
// Assertion macros for the trajectory collision check block.
`ifndef TRAJECTORY_COLLISION_CHECK_TOP_ASSERT_SVH
`define TRAJECTORY_COLLISION_CHECK_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TCC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define TCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/tcc_pkg.sv
// Package with shared constants, types and tables of the trajectory collision check.
package tcc_pkg;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int CELL_LOG2 = 8;
  localparam int COL_W = $clog2(GRID_X);
  localparam int ROW_W = $clog2(GRID_Y);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int CELLS = GRID_X * GRID_Y;
  localparam int POS_W = 18;
  localparam int ANG_W = 16;
  localparam int CORDIC_STEPS = 14;
  localparam int ITER_W = 4;
  localparam int CORDIC_GAIN = 19898;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam logic [0:0] REG_TIME_STEP = 1'b0;
  localparam logic [0:0] REG_ROBOT_RADIUS = 1'b1;

  typedef struct packed {
    logic start;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [9:0] radius;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

  function automatic logic [15:0] atan_lut(input logic [ITER_W-1:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0: v = 16'd8192;
      4'd1: v = 16'd4836;
      4'd2: v = 16'd2555;
      4'd3: v = 16'd1297;
      4'd4: v = 16'd651;
      4'd5: v = 16'd326;
      4'd6: v = 16'd163;
      4'd7: v = 16'd81;
      4'd8: v = 16'd41;
      4'd9: v = 16'd20;
      4'd10: v = 16'd10;
      4'd11: v = 16'd5;
      4'd12: v = 16'd3;
      4'd13: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/tcc_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module tcc_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tcc_pkg::ANG_W-1:0]   angle,
  output logic                        done,
  output logic signed [17:0]          cos_out,
  output logic signed [17:0]          sin_out
);
  import tcc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t state;
  logic [ITER_W-1:0] iter;
  logic signed [17:0] x;
  logic signed [17:0] y;
  logic signed [17:0] z;
  logic neg;
  logic signed [17:0] xs;
  logic signed [17:0] ys;
  logic signed [17:0] z0;
  logic signed [17:0] at;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign z0 = 18'(signed'(angle));
  assign at = 18'(atan_lut(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x <= 18'sd19898;
            y <= '0;
            iter <= '0;
            if (z0 > 18'sd16384) begin
              z <= z0 - 18'sd32768;
              neg <= 1'b1;
            end else if (z0 < -18'sd16384) begin
              z <= z0 + 18'sd32768;
              neg <= 1'b1;
            end else begin
              z <= z0;
              neg <= 1'b0;
            end
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!z[17]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          if (iter == ITER_W'(CORDIC_STEPS - 1)) state <= S_FIN;
          iter <= iter + 1'b1;
        end
        S_FIN: begin
          cos_out <= neg ? -x : x;
          sin_out <= neg ? -y : y;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/tcc_grid_scan.sv
// Occupancy map memory with a clearing pass and a serial footprint scan.
module tcc_grid_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [tcc_pkg::COL_W-1:0]    wr_col,
  input  logic [tcc_pkg::ROW_W-1:0]    wr_row,
  input  logic                         wr_data,
  input  tcc_pkg::scan_req_t           req,
  output tcc_pkg::scan_rsp_t           rsp,
  output logic                         clearing
);
  import tcc_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SPAN, S_READ, S_TEST} state_t;

  state_t state;
  logic mem [CELLS];
  logic [ADDR_W:0] clr_cnt;
  logic rd_data;
  logic [COL_W-1:0] cx;
  logic [COL_W-1:0] x1;
  logic [ROW_W-1:0] cy;
  logic [ROW_W-1:0] y0;
  logic [ROW_W-1:0] y1;
  logic signed [POS_W:0] px;
  logic signed [POS_W:0] py;
  logic [9:0] rad;
  logic signed [POS_W:0] xa;
  logic signed [POS_W:0] xb;
  logic signed [POS_W:0] ya;
  logic signed [POS_W:0] yb;
  logic signed [POS_W:0] xal;
  logic signed [POS_W:0] xbl;
  logic signed [POS_W:0] yal;
  logic signed [POS_W:0] ybl;
  logic empty;
  logic mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic mem_wd;
  logic [ADDR_W-1:0] rd_addr;

  assign xa = px - (POS_W+1)'(rad);
  assign xb = px + (POS_W+1)'(rad);
  assign ya = py - (POS_W+1)'(rad);
  assign yb = py + (POS_W+1)'(rad);
  assign xal = xa >>> CELL_LOG2;
  assign xbl = xb >>> CELL_LOG2;
  assign yal = ya >>> CELL_LOG2;
  assign ybl = yb >>> CELL_LOG2;
  assign empty = (xbl < 0) || (xal > (POS_W+1)'(GRID_X - 1))
              || (ybl < 0) || (yal > (POS_W+1)'(GRID_Y - 1));
  assign clearing = (state == S_CLEAR);
  assign rd_addr = {cx, cy};

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt[ADDR_W-1:0];
      mem_wd = 1'b0;
    end else begin
      mem_we = wr_en;
      mem_wa = {wr_col, wr_row};
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      rsp <= '0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ADDR_W+1)'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.start) begin
            px <= (POS_W+1)'(signed'(req.pos_x));
            py <= (POS_W+1)'(signed'(req.pos_y));
            rad <= req.radius;
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          if (empty) begin
            rsp.done <= 1'b1;
            rsp.hit <= 1'b0;
            state <= S_IDLE;
          end else begin
            x1 <= xbl > (POS_W+1)'(GRID_X - 1) ? COL_W'(GRID_X - 1) : COL_W'(xbl);
            y0 <= yal < 0 ? '0 : ROW_W'(yal);
            y1 <= ybl > (POS_W+1)'(GRID_Y - 1) ? ROW_W'(GRID_Y - 1) : ROW_W'(ybl);
            cx <= xal < 0 ? '0 : COL_W'(xal);
            cy <= yal < 0 ? '0 : ROW_W'(yal);
            state <= S_READ;
          end
        end
        S_READ: state <= S_TEST;
        S_TEST: begin
          if (rd_data) begin
            rsp.done <= 1'b1;
            rsp.hit <= 1'b1;
            state <= S_IDLE;
          end else if (cy == y1 && cx == x1) begin
            rsp.done <= 1'b1;
            rsp.hit <= 1'b0;
            state <= S_IDLE;
          end else begin
            if (cy == y1) begin
              cy <= y0;
              cx <= cx + 1'b1;
            end else begin
              cy <= cy + 1'b1;
            end
            state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/trajectory_collision_check_top.sv
// Top level of the trajectory rollout with occupancy grid collision check.
//
//  channel   | ports                                              | handshake
//  request   | opcode cell_col cell_row occupied start_* turn_rate speed | start/busy
//  result    | pred_x pred_y pred_heading step_hit any_hit         | done strobe
//  config    | psel penable pwrite paddr pwdata prdata pready      | APB write
//
// A map write, start or unused-opcode request is taken and busy stays low.
// A step strobes its result after its heading, CORDIC and offset states and a footprint
// scan; the scan stops at the first occupied cell and busy drops in the following cycle.
// The CORDIC iterations and the single map read port set the step length.
// After reset the map clearing pass holds busy high.
// The result strobe lasts one cycle and cannot be stalled.
module trajectory_collision_check_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode,
  input  logic [5:0]          cell_col,
  input  logic [5:0]          cell_row,
  input  logic                occupied,
  input  logic signed [17:0]  start_x,
  input  logic signed [17:0]  start_y,
  input  logic [15:0]         start_heading,
  input  logic signed [15:0]  turn_rate,
  input  logic [15:0]         speed,
  output logic                done,
  output logic signed [17:0]  pred_x,
  output logic signed [17:0]  pred_y,
  output logic [15:0]         pred_heading,
  output logic                step_hit,
  output logic                any_hit,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tcc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_TRIG, S_DIST, S_DX, S_DY, S_POS, S_SCAN}
    state_t;

  state_t state;
  logic [15:0] time_step;
  logic [9:0] robot_radius;
  logic signed [POS_W-1:0] pose_x;
  logic signed [POS_W-1:0] pose_y;
  logic [ANG_W-1:0] pose_heading;
  logic hit_seen;
  logic signed [15:0] tr_q;
  logic [15:0] spd_q;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic signed [51:0] prod_r;
  logic [31:0] travel;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic cordic_start;
  logic cordic_done;
  logic signed [17:0] cos_v;
  logic signed [17:0] sin_v;
  scan_req_t sreq;
  scan_rsp_t srsp;
  logic clearing;
  logic accept;
  logic map_we;
  logic cfg_wr;
  logic signed [51:0] rnd;

  assign pready = 1'b1;
  assign accept = start && !busy;
  assign map_we = accept && opcode_t'(opcode) == OP_WRITE;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {22'd0, robot_radius} : {16'd0, time_step};
  assign prod = mul_a * mul_b;
  assign rnd = prod_r + 52'sd1073741824;

  always_comb begin
    unique case (state)
      S_HEAD: begin
        mul_a = 34'(tr_q);
        mul_b = 18'(signed'({1'b0, time_step}));
      end
      S_DIST: begin
        mul_a = 34'(signed'({1'b0, spd_q}));
        mul_b = 18'(signed'({1'b0, time_step}));
      end
      S_DX: begin
        mul_a = 34'(signed'({1'b0, travel}));
        mul_b = cos_v;
      end
      default: begin
        mul_a = 34'(signed'({1'b0, travel}));
        mul_b = sin_v;
      end
    endcase
  end

  tcc_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .angle(pose_heading),
    .done(cordic_done), .cos_out(cos_v), .sin_out(sin_v)
  );

  tcc_grid_scan u_scan (
    .clk(clk), .rst(rst), .wr_en(map_we), .wr_col(cell_col), .wr_row(cell_row),
    .wr_data(occupied), .req(sreq), .rsp(srsp), .clearing(clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 16'd6554;
      robot_radius <= 10'd128;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TIME_STEP) time_step <= pwdata[15:0];
      else robot_radius <= pwdata[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b1;
      done <= 1'b0;
      cordic_start <= 1'b0;
      sreq <= '0;
      pose_x <= '0;
      pose_y <= '0;
      pose_heading <= '0;
      hit_seen <= 1'b0;
    end else begin
      done <= 1'b0;
      cordic_start <= 1'b0;
      sreq.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          busy <= clearing;
          if (accept) begin
            if (opcode_t'(opcode) == OP_START) begin
              pose_x <= start_x;
              pose_y <= start_y;
              pose_heading <= start_heading;
              hit_seen <= 1'b0;
            end else if (opcode_t'(opcode) == OP_STEP) begin
              tr_q <= turn_rate;
              spd_q <= speed;
              busy <= 1'b1;
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          pose_heading <= pose_heading + 16'((prod + 52'sd32768) >>> 16);
          cordic_start <= 1'b1;
          state <= S_DIST;
        end
        S_DIST: begin
          travel <= prod[31:0];
          state <= S_TRIG;
        end
        S_TRIG: begin
          if (cordic_done) state <= S_DX;
        end
        S_DX: begin
          prod_r <= prod;
          state <= S_DY;
        end
        S_DY: begin
          dx <= 18'(rnd >>> 31);
          prod_r <= prod;
          state <= S_POS;
        end
        S_POS: begin
          pose_x <= pose_x + dx;
          pose_y <= pose_y + 18'(rnd >>> 31);
          sreq.start <= 1'b1;
          sreq.pos_x <= pose_x + dx;
          sreq.pos_y <= pose_y + 18'(rnd >>> 31);
          sreq.radius <= robot_radius;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (srsp.done) begin
            done <= 1'b1;
            pred_x <= pose_x;
            pred_y <= pose_y;
            pred_heading <= pose_heading;
            step_hit <= srsp.hit;
            any_hit <= hit_seen | srsp.hit;
            hit_seen <= hit_seen | srsp.hit;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/tcc_checker.sv
// Port-level assertion checker for the trajectory collision check, with its bind.
`include "trajectory_collision_check_top_assert.svh"
module tcc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic [1:0] opcode,
  input logic done,
  input logic step_hit,
  input logic any_hit,
  input logic pready
);
  import tcc_pkg::*;

  `TCC_ASSERT_IMPL(a_hit_sticky, done && step_hit, any_hit)
  `TCC_ASSERT_NEXT(a_done_single, done, !done)
  `TCC_ASSERT_IMPL(a_pready, 1'b1, pready)
  `TCC_ASSERT_NEXT(a_step_busy, start && !busy && opcode == OP_STEP, busy)
endmodule

bind trajectory_collision_check_top tcc_checker u_tcc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .done(done),
  .step_hit(step_hit), .any_hit(any_hit), .pready(pready)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the trajectory rollout and occupancy grid collision check.
`timescale 1ns / 100ps

class pose_scoreboard;
  bit occ_map [0:4095];
  logic signed [17:0] pose_x;
  logic signed [17:0] pose_y;
  logic [15:0] pose_heading;
  bit hit_seen;
  logic [15:0] time_step;
  logic [9:0] robot_radius;
  logic [53:0] expected_poses [$];
  int errors;
  int results_seen;

  function new();
    foreach (occ_map[i]) occ_map[i] = 0;
    pose_x = 0;
    pose_y = 0;
    pose_heading = 0;
    hit_seen = 0;
    time_step = 16'd6554;
    robot_radius = 10'd128;
    errors = 0;
    results_seen = 0;
  endfunction

  function automatic void rotate(input logic [15:0] angle, output int c, output int s);
    int z;
    int x;
    int y;
    int xs;
    int ys;
    bit neg;
    int atans [14];
    atans = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    z = angle;
    x = tcc_pkg::CORDIC_GAIN;
    y = 0;
    neg = 0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768;
      neg = 1;
    end else if (z < -16384) begin
      z += 32768;
      neg = 1;
    end
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atans[i];
      end else begin
        x += ys;
        y -= xs;
        z += atans[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic void cell_span(input int p, input int lim, output int lo, output int hi);
    lo = (p - int'(robot_radius)) >>> tcc_pkg::CELL_LOG2;
    hi = (p + int'(robot_radius)) >>> tcc_pkg::CELL_LOG2;
    if (lo < 0) lo = 0;
    if (hi > lim - 1) hi = lim - 1;
  endfunction

  function void note_request(input tcc_pkg::opcode_t op, input logic [5:0] col,
                             input logic [5:0] row, input bit occ,
                             input logic signed [17:0] sx, input logic signed [17:0] sy,
                             input logic [15:0] sh, input logic signed [15:0] rate,
                             input logic [15:0] spd);
    longint tr;
    longint travel;
    longint dx;
    longint dy;
    int c;
    int s;
    int x0;
    int x1;
    int y0;
    int y1;
    bit hit;
    logic [53:0] entry;
    case (op)
      tcc_pkg::OP_WRITE: begin
        occ_map[{col, row}] = occ;
      end
      tcc_pkg::OP_START: begin
        pose_x = sx;
        pose_y = sy;
        pose_heading = sh;
        hit_seen = 0;
      end
      tcc_pkg::OP_STEP: begin
        tr = (longint'(rate) * longint'(time_step) + 32768) >>> 16;
        pose_heading = pose_heading + tr[15:0];
        rotate(pose_heading, c, s);
        travel = longint'(spd) * longint'(time_step);
        dx = (travel * c + (64'sd1 <<< 30)) >>> 31;
        dy = (travel * s + (64'sd1 <<< 30)) >>> 31;
        pose_x = pose_x + dx[17:0];
        pose_y = pose_y + dy[17:0];
        cell_span(pose_x, tcc_pkg::GRID_X, x0, x1);
        cell_span(pose_y, tcc_pkg::GRID_Y, y0, y1);
        hit = 0;
        for (int cx = x0; cx <= x1; cx++)
          for (int cy = y0; cy <= y1; cy++)
            if (occ_map[cx * 64 + cy]) hit = 1;
        if (hit) hit_seen = 1;
        entry = {pose_x, pose_y, pose_heading, hit, hit_seen};
        expected_poses = {expected_poses, entry};
      end
      default: begin
      end
    endcase
  endfunction

  function void check_result(input logic [53:0] got);
    logic [53:0] want;
    results_seen++;
    if (expected_poses.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
      errors++;
    end else begin
      want = expected_poses.pop_front();
      if (want[53:36] !== got[53:36]) begin
        $display("%0t: pred_x expected %0d actual %0d", $realtime,
                 $signed(want[53:36]), $signed(got[53:36]));
        errors++;
      end
      if (want[35:18] !== got[35:18]) begin
        $display("%0t: pred_y expected %0d actual %0d", $realtime,
                 $signed(want[35:18]), $signed(got[35:18]));
        errors++;
      end
      if (want[17:2] !== got[17:2]) begin
        $display("%0t: pred_heading expected %0d actual %0d", $realtime,
                 want[17:2], got[17:2]);
        errors++;
      end
      if (want[1] !== got[1]) begin
        $display("%0t: step_hit expected %0d actual %0d", $realtime, want[1], got[1]);
        errors++;
      end
      if (want[0] !== got[0]) begin
        $display("%0t: any_hit expected %0d actual %0d", $realtime, want[0], got[0]);
        errors++;
      end
    end
  endfunction
endclass

module tb_top;
  import tcc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] opcode = 0;
  logic [5:0] cell_col = 0;
  logic [5:0] cell_row = 0;
  logic occupied = 0;
  logic signed [17:0] start_x = 0;
  logic signed [17:0] start_y = 0;
  logic [15:0] start_heading = 0;
  logic signed [15:0] turn_rate = 0;
  logic [15:0] speed = 0;
  logic done;
  logic signed [17:0] pred_x;
  logic signed [17:0] pred_y;
  logic [15:0] pred_heading;
  logic step_hit;
  logic any_hit;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  pose_scoreboard sb;
  int cycles = 0;
  int idle_pct = 0;
  bit timed_out = 0;

  trajectory_collision_check_top u_top (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result({pred_x, pred_y, pred_heading, step_hit, any_hit});
    if (cycles > 3000000 && !timed_out) begin
      timed_out = 1;
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_TIME_STEP) sb.time_step = value[15:0];
    else sb.robot_radius = value[9:0];
    @(posedge clk);
  endtask

  task automatic send(input opcode_t op, input logic [5:0] col, input logic [5:0] row,
                      input bit occ, input logic signed [17:0] sx,
                      input logic signed [17:0] sy, input logic [15:0] sh,
                      input logic signed [15:0] rate, input logic [15:0] spd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    opcode <= op;
    cell_col <= col;
    cell_row <= row;
    occupied <= occ;
    start_x <= sx;
    start_y <= sy;
    start_heading <= sh;
    turn_rate <= rate;
    speed <= spd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, col, row, occ, sx, sy, sh, rate, spd);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_poses.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_request(input int mode);
    int pick;
    pick = $urandom_range(99);
    if (pick < 25)
      send(OP_WRITE, 6'($urandom), 6'($urandom), $urandom_range(99) < 40, 0, 0, 0, 0, 0);
    else if (pick < 33)
      send(OP_START, 0, 0, 0,
           mode ? 18'($urandom) : 18'($urandom_range(16383)),
           mode ? 18'($urandom) : 18'($urandom_range(16383)), 16'($urandom), 0, 0);
    else if (pick < 35)
      send(OP_NONE, 6'($urandom), 6'($urandom), 1'($urandom), 18'($urandom),
           18'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send(OP_STEP, 0, 0, 0, 0, 0, 0, 16'($urandom),
           ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2047)));
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(OP_WRITE, 0, 0, 1, 0, 0, 0, 0, 0);
    send(OP_WRITE, 63, 63, 1, 0, 0, 0, 0, 0);
    send(OP_WRITE, 10, 20, 1, 0, 0, 0, 0, 0);
    send(OP_WRITE, 10, 20, 0, 0, 0, 0, 0, 0);
    send(OP_NONE, 63, 63, 1, -1, -1, 16'hFFFF, -1, 16'hFFFF);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_START, 0, 0, 0, 18'sd100, 18'sd100, 16'd0, 0, 0);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, 16'sd32767, 16'd65535);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, -16'sd32768, 16'd65535);
    send(OP_START, 0, 0, 0, 18'sd131071, -18'sd131072, 16'hFFFF, 0, 0);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 16'd40000);
    send(OP_START, 0, 0, 0, 18'sd16300, 18'sd16300, 16'h8000, 0, 0);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, 16'sd5000, 16'd300);
    send(OP_START, 0, 0, 0, -18'sd5000, 18'sd300, 16'h4000, 0, 0);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, -16'sd5000, 16'd1000);
    drain();

    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_ROBOT_RADIUS, 32'd1023);
    send(OP_START, 0, 0, 0, 18'sd200, 18'sd200, 16'd0, 0, 0);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, 16'sd1234, 16'd9999);
    send(OP_START, 0, 0, 0, 18'sd8000, 18'sd8000, 16'd0, 0, 0);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, 16'sd1234, 16'd9999);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(REG_TIME_STEP, 32'd65535); write_reg(REG_ROBOT_RADIUS, 32'd0); end
        1: begin write_reg(REG_TIME_STEP, 32'd1); write_reg(REG_ROBOT_RADIUS, 32'd300); end
        2: begin write_reg(REG_TIME_STEP, 32'd6554); write_reg(REG_ROBOT_RADIUS, 32'd128); end
        3: begin write_reg(REG_TIME_STEP, $urandom); write_reg(REG_ROBOT_RADIUS, $urandom); end
        default: begin
          write_reg(REG_TIME_STEP, 32'd20000);
          write_reg(REG_ROBOT_RADIUS, 32'd600);
        end
      endcase
      idle_pct = (phase == 0) ? 37 : (phase == 1) ? 54 : 0;
      for (int n = 0; n < 190; n++) random_request(phase == 3);
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/tcc_pkg.sv
rtl/tcc_cordic.sv
rtl/tcc_grid_scan.sv
rtl/trajectory_collision_check_top.sv
rtl/tcc_checker.sv
tb/sv/tb_top.sv
